/* hdl/ckre_pkg.sv */
// Shared constants, types and register codes for the color-key run extractor.
package ckre_pkg;

  // Sizing
  localparam int KEY_COLORS = 4;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int KEY_SLOTS = 4;
  localparam int KEY_LIMIT = (KEY_COLORS < KEY_SLOTS) ? KEY_COLORS : KEY_SLOTS;

  localparam int PIX_W    = 24;
  localparam int KEY_W    = 2;
  localparam int KEYCNT_W = 3;
  localparam int COL_W    = $clog2(MAX_WIDTH + 1);
  localparam int START_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);

  localparam int RES_BITS    = ROW_W + START_W + COL_W + KEY_W;
  localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;
  localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;

  localparam logic [PIX_W-1:0] BLACK_PIXEL = 24'h000000;
  localparam logic [PIX_W-1:0] WHITE_PIXEL = 24'hFFFFFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_BW  = 3'd5;

  localparam logic [KEYCNT_W-1:0] KEY_COUNT_RESET = 3'd1;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KEY_SLOTS-1:0][PIX_W-1:0] key_color;
    logic [KEYCNT_W-1:0]             key_count;
    logic                            exclude_bw;
  } cfg_t;

  typedef struct packed {
    logic                last;
    logic [KEY_W-1:0]    key;
    logic [COL_W-1:0]    end_col;
    logic [START_W-1:0]  start_col;
    logic [ROW_W-1:0]    row;
  } result_t;

  // Up to two results per pixel; first holds the only one when cnt is 1
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* hdl/ckre_cfg_regs.sv */
// Configuration register file: key colors, key count and black/white exclusion.
module ckre_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [ckre_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ckre_pkg::PIX_W-1:0]     wr_data,
  output ckre_pkg::cfg_t                 cfg
);

  ckre_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        ckre_pkg::REG_KEY_COLOR_0: cfg_nxt.key_color[0] = wr_data;
        ckre_pkg::REG_KEY_COLOR_1: cfg_nxt.key_color[1] = wr_data;
        ckre_pkg::REG_KEY_COLOR_2: cfg_nxt.key_color[2] = wr_data;
        ckre_pkg::REG_KEY_COLOR_3: cfg_nxt.key_color[3] = wr_data;
        ckre_pkg::REG_KEY_COUNT:   cfg_nxt.key_count = wr_data[ckre_pkg::KEYCNT_W-1:0];
        ckre_pkg::REG_EXCLUDE_BW:  cfg_nxt.exclude_bw = wr_data[0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r            <= '0;
      cfg_r.key_count  <= ckre_pkg::KEY_COUNT_RESET;
      cfg_r.exclude_bw <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/ckre_run_tracker.sv */
// Run state registers and per-pixel match / close / open decisions.
module ckre_run_tracker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [ckre_pkg::PIX_W-1:0] pixel,
  input  logic                       row_end,
  input  logic                       frame_start,
  input  ckre_pkg::cfg_t             cfg,
  output ckre_pkg::push_t            push
);

  logic                           run_open_r, run_open_nxt;
  logic [ckre_pkg::KEY_W-1:0]     open_key_r, open_key_nxt;
  logic [ckre_pkg::START_W-1:0]   open_start_r, open_start_nxt;
  logic [ckre_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [ckre_pkg::ROW_W-1:0]     row_r, row_nxt;

  logic                           open_cur;
  logic [ckre_pkg::COL_W-1:0]     col;
  logic [ckre_pkg::ROW_W-1:0]     row;
  logic                           in_range;
  logic [ckre_pkg::KEYCNT_W-1:0]  keys;
  logic [ckre_pkg::KEY_SLOTS-1:0] hit;
  logic                           any_hit;
  logic [ckre_pkg::KEY_W-1:0]     hit_idx;
  logic                           keep, excluded, close1, open2, close2;
  logic                           open_mid;
  logic [ckre_pkg::KEY_W-1:0]     key_mid;
  logic [ckre_pkg::START_W-1:0]   start_mid;
  logic [ckre_pkg::COL_W-1:0]     end2;
  ckre_pkg::result_t              res1, res2;

  always_comb begin
    // frame start wipes position and drops any open run
    open_cur = frame_start ? 1'b0 : run_open_r;
    col      = frame_start ? '0 : col_r;
    row      = frame_start ? '0 : row_r;
    in_range = col < ckre_pkg::COL_W'(ckre_pkg::MAX_WIDTH);

    keys = (cfg.key_count > ckre_pkg::KEYCNT_W'(ckre_pkg::KEY_LIMIT)) ?
           ckre_pkg::KEYCNT_W'(ckre_pkg::KEY_LIMIT) : cfg.key_count;

    for (int i = 0; i < ckre_pkg::KEY_SLOTS; i++) begin
      hit[i] = (pixel == cfg.key_color[i]) && (ckre_pkg::KEYCNT_W'(i) < keys);
    end
    any_hit = |hit;
    hit_idx = '0;
    for (int i = ckre_pkg::KEY_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = ckre_pkg::KEY_W'(i);
    end

    keep     = open_cur && (pixel == cfg.key_color[open_key_r]);
    excluded = cfg.exclude_bw &&
               (pixel == ckre_pkg::BLACK_PIXEL || pixel == ckre_pkg::WHITE_PIXEL);
    close1   = in_range && open_cur && !keep;
    open2    = in_range && !keep && !excluded && any_hit;

    open_mid  = in_range ? (keep || open2) : open_cur;
    key_mid   = open2 ? hit_idx : open_key_r;
    start_mid = open2 ? col[ckre_pkg::START_W-1:0] : open_start_r;
    close2    = row_end && open_mid;
    end2      = in_range ? col + 1'b1 : ckre_pkg::COL_W'(ckre_pkg::MAX_WIDTH);

    res1.row       = row;
    res1.start_col = open_start_r;
    res1.end_col   = col;
    res1.key       = open_key_r;
    res1.last      = !close2;

    res2.row       = row;
    res2.start_col = start_mid;
    res2.end_col   = end2;
    res2.key       = key_mid;
    res2.last      = 1'b1;

    push.cnt    = accept ? ({1'b0, close1} + {1'b0, close2}) : 2'd0;
    push.first  = close1 ? res1 : res2;
    push.second = res2;

    run_open_nxt   = run_open_r;
    open_key_nxt   = open_key_r;
    open_start_nxt = open_start_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    if (accept) begin
      run_open_nxt   = row_end ? 1'b0 : open_mid;
      open_key_nxt   = key_mid;
      open_start_nxt = start_mid;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row < ckre_pkg::ROW_W'(ckre_pkg::MAX_HEIGHT - 1)) ? row + 1'b1 : row;
      end else begin
        col_nxt = in_range ? col + 1'b1 : col;
        row_nxt = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r   <= 1'b0;
      open_key_r   <= '0;
      open_start_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
    end else begin
      run_open_r   <= run_open_nxt;
      open_key_r   <= open_key_nxt;
      open_start_r <= open_start_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

  // column counter saturates at the maximum width
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= ckre_pkg::COL_W'(ckre_pkg::MAX_WIDTH))
    else $error("column counter beyond max width");

  // a row end always leaves no run open
  a_row_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    accept && row_end |=> !run_open_r && col_r == '0)
    else $error("run still open after row end");

endmodule

/* hdl/ckre_out_queue.sv */
// Small result queue: takes up to two results per cycle, hands out one.
module ckre_out_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ckre_pkg::push_t                  push,
  output logic                             room,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ckre_pkg::result_t                out_res
);

  ckre_pkg::result_t                 entry_r [ckre_pkg::QDEPTH];
  logic [ckre_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ckre_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ckre_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              pop;
  logic [ckre_pkg::QPTR_W-1:0]       wr_ptr_p1;

  assign out_valid = cnt_r != '0;
  assign out_res   = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // two free slots guarantee the worst-case pixel fits
  assign room      = cnt_r <= ckre_pkg::QCNT_W'(ckre_pkg::QDEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ckre_pkg::QPTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + ckre_pkg::QCNT_W'(push.cnt) - ckre_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) entry_r[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) entry_r[wr_ptr_p1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd0 || room)
    else $error("result pushed without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ckre_pkg::QCNT_W'(ckre_pkg::QDEPTH) &&
    (wr_ptr_r - rd_ptr_r) == cnt_r[ckre_pkg::QPTR_W-1:0])
    else $error("queue pointers and count disagree");

endmodule

/* hdl/color_key_run_extractor_unit.sv */
// Color-key run extractor top level: config port, run tracker and result queue.
// A run's result is registered in the result queue and offered on out_* from its head.
// Throughput: one pixel per cycle; a pixel that closes two runs pushes two results,
//   and the four-entry result queue stalls in_tready when fewer than two slots are free.
// Reset (rst_n low, synchronous): no run open, row and column 0, queue empty,
//   key colors 0, key count 1, black/white exclusion on.
module color_key_run_extractor_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [23:0] pixel_value
  input  logic [ckre_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tlast,   // row_end
  input  logic                                 in_tuser,   // frame_start
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: [10:0] run_row, [21:11] run_start_col, [33:22] run_end_col,
  //            [35:34] run_key, rest zero
  output logic [ckre_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,  // last_result
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ckre_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ckre_pkg::PIX_W-1:0]           cfg_data
);

  ckre_pkg::cfg_t    cfg;
  ckre_pkg::push_t   push;
  ckre_pkg::result_t res;
  logic              room;
  logic              in_accept;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_accept = in_tvalid && room;

  ckre_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ckre_run_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .pixel       (in_tdata[ckre_pkg::PIX_W-1:0]),
    .row_end     (in_tlast),
    .frame_start (in_tuser),
    .cfg         (cfg),
    .push        (push)
  );

  ckre_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = ckre_pkg::OUT_TDATA_W'({res.key, res.end_col, res.start_col, res.row});
  assign out_tlast = res.last;

endmodule
